// ----- sv/lzwz_pkg.sv -----
// Package for the .Z (LZW) decoder: sizes, status codes, dictionary request type.
package lzwz_pkg;

	localparam int LZWZ_MAX_BITS = 16;
	localparam int LZWZ_AW_MAX   = 16;
	localparam int LZWZ_GRP_BYTES = 16;

	localparam logic [7:0] LZWZ_MAGIC0 = 8'h1F;
	localparam logic [7:0] LZWZ_MAGIC1 = 8'h9D;
	localparam logic [4:0] LZWZ_MIN_W  = 5'd9;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_WIDTH    = 3'd3,
		ST_CODE     = 3'd4,
		ST_MISPLACE = 3'd5
	} lzwz_status_t;

	typedef enum logic {
		FN_PUSH = 1'b0,
		FN_PULL = 1'b1
	} lzwz_func_t;

	// dictionary and expansion-stack port requests
	typedef struct packed {
		logic [LZWZ_AW_MAX-1:0] d_raddr;
		logic                   p_we;
		logic [LZWZ_AW_MAX-1:0] p_waddr;
		logic [15:0]            p_wdata;
		logic                   s_we;
		logic [LZWZ_AW_MAX-1:0] s_waddr;
		logic [7:0]             s_wdata;
		logic [LZWZ_AW_MAX-1:0] k_raddr;
		logic                   k_we;
		logic [LZWZ_AW_MAX-1:0] k_waddr;
		logic [7:0]             k_wdata;
	} lzwz_mem_req_t;

endpackage

// ----- sv/lzw_compress_z_decoder_core.sv -----
// Top level of the .Z (LZW) stream decoder: request sequencer and code extraction.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  request | in_valid / in_stall  | func, in_byte, in_last
//  result  | rsp_valid / rsp_stall| out_byte, out_valid, need_input, finished,
//          |                      | status
//  config  | cfg_we               | cfg_wdata (out_limit)
//
// A push is answered from the idle state. A pull that pops a waiting byte goes
// through accept, stack read and result. A pull that decodes a new code is
// accepted, extracts the code, makes one chain step per parent/suffix memory read,
// closes the string (S_FIN, plus S_FIX for KwKwK), then pops the first byte;
// clear codes and dropped-limit flushes each add a pass through S_LOOP. The
// dictionary read port sets the pace. One transaction is worked at a time;
// in_stall is high from acceptance until the result register is free again.
// Reset clears control state only; memories are not cleared (the only read of an
// unwritten entry is the suffix in the KwKwK case, and that byte is replaced).
module lzw_compress_z_decoder_core #(
	parameter int MAX_BITS = lzwz_pkg::LZWZ_MAX_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// result
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        need_input,
	output logic        finished,
	output logic [2:0]  status,
	// configuration
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import lzwz_pkg::*;

	localparam int AW = MAX_BITS;      // dictionary address bits
	localparam int NW = MAX_BITS + 1;  // next_code / stack count bits
	localparam int GB = LZWZ_GRP_BYTES * 8;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOOP = 6'b000010,
		S_WALK = 6'b000100,
		S_FIN  = 6'b001000,
		S_FIX  = 6'b010000,
		S_POP  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [31:0]   out_limit_q;
	logic [31:0]   out_count_q;
	logic [GB-1:0] gbuf_q;
	logic [7:0]    gbits_q;
	logic [7:0]    bp_q;
	logic [4:0]    cw_q;
	logic [4:0]    mw_q;
	logic          bm_q;
	logic [NW-1:0] nc_q;
	logic          need_prev_q;
	logic [1:0]    hc_q;
	logic          ended_q;
	logic [2:0]    err_q;
	logic [NW-1:0] stk_cnt_q;
	logic [NW-1:0] n_q;
	logic [15:0]   code_q;
	logic [15:0]   cur_q;

	// result register
	logic          rsp_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_valid_q;
	logic          need_q;
	logic          fin_q;
	logic [2:0]    status_q;

	lzwz_mem_req_t req;
	logic [15:0]   par_rd;
	logic [7:0]    suf_rd;
	logic [7:0]    stk_rd;

	lzwz_dict #(.AW(AW)) u_dict (
		.clk    (clk),
		.req    (req),
		.par_rd (par_rd),
		.suf_rd (suf_rd),
		.stk_rd (stk_rd)
	);

	// shared extraction unit: barrel shift of the group buffer
	logic [GB-1:0] shifted;
	logic [15:0]   cw_mask;
	logic [15:0]   code_raw;
	logic          code_fits;
	logic          grp_full;
	logic [NW-1:0] nc_m1;
	logic [NW-1:0] code_ext;
	logic          lim_ok;
	logic [NW-1:0] pow_mw;
	logic [NW-1:0] pow_cw;
	logic [NW-1:0] nc_p1;
	logic [NW-1:0] n_p1;
	logic [NW-1:0] stk_m1;
	logic          in_acc;
	logic          hdr_magic_ok;
	logic          hdr_width_ok;
	logic [4:0]    hdr_w;

	assign shifted   = gbuf_q >> bp_q;
	assign cw_mask   = 16'((17'd1 << cw_q) - 17'd1);
	assign code_raw  = shifted[15:0] & cw_mask;
	assign code_fits = ({1'b0, bp_q} + 9'(cw_q)) <= {1'b0, gbits_q};
	assign grp_full  = gbits_q >= {cw_q, 3'b000};
	assign nc_m1     = nc_q - NW'(1);
	assign nc_p1     = nc_q + NW'(1);
	assign n_p1      = n_q + NW'(1);
	assign stk_m1    = stk_cnt_q - NW'(1);
	assign code_ext  = NW'(code_raw);
	assign lim_ok    = out_count_q < out_limit_q;
	assign pow_mw    = NW'(1) << mw_q;
	assign pow_cw    = NW'(1) << cw_q;
	assign in_acc    = in_valid && !in_stall;

	assign hdr_w        = in_byte[4:0];
	assign hdr_magic_ok = (gbuf_q[7:0] == LZWZ_MAGIC0) && (gbuf_q[15:8] == LZWZ_MAGIC1);
	assign hdr_width_ok = (hdr_w >= LZWZ_MIN_W) && (32'(hdr_w) <= 32'(MAX_BITS));

	assign in_stall   = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign rsp_valid  = rsp_valid_q;
	assign out_byte   = out_byte_q;
	assign out_valid  = out_valid_q;
	assign need_input = need_q;
	assign finished   = fin_q;
	assign status     = status_q;

	// memory requests
	always_comb begin
		req = '0;
		req.d_raddr = (state_q == S_WALK) ? par_rd : code_raw;
		req.k_raddr = LZWZ_AW_MAX'(stk_m1);
		unique case (state_q)
			S_WALK: begin
				req.k_we    = 1'b1;
				req.k_waddr = LZWZ_AW_MAX'(n_q);
				req.k_wdata = suf_rd;
			end
			S_FIN: begin
				req.k_we    = 1'b1;
				req.k_waddr = LZWZ_AW_MAX'(n_q);
				req.k_wdata = cur_q[7:0];
				req.s_we    = need_prev_q;
				req.s_waddr = LZWZ_AW_MAX'(nc_m1);
				req.s_wdata = cur_q[7:0];
				req.p_we    = nc_q < pow_mw;
				req.p_waddr = LZWZ_AW_MAX'(nc_q);
				req.p_wdata = code_q;
			end
			S_FIX: begin
				req.k_we    = 1'b1;
				req.k_waddr = '0;
				req.k_wdata = cur_q[7:0];
			end
			S_IDLE, S_LOOP, S_POP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_limit_q <= '0;
			out_count_q <= '0;
			gbits_q     <= '0;
			bp_q        <= '0;
			cw_q        <= LZWZ_MIN_W;
			mw_q        <= '0;
			bm_q        <= 1'b0;
			nc_q        <= NW'(256);
			need_prev_q <= 1'b0;
			hc_q        <= '0;
			ended_q     <= 1'b0;
			err_q       <= ST_OK;
			stk_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				out_limit_q <= cfg_wdata;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						out_byte_q  <= '0;
						out_valid_q <= 1'b0;
						need_q      <= 1'b0;
						fin_q       <= 1'b0;
						status_q    <= ST_OK;
						if (func == FN_PULL) begin
							if (err_q != ST_OK) begin
								rsp_valid_q <= 1'b1;
								fin_q       <= 1'b1;
								status_q    <= err_q;
							end else if (hc_q != 2'd3) begin
								rsp_valid_q <= 1'b1;
								need_q      <= 1'b1;
							end else begin
								state_q <= S_LOOP;
							end
						end else begin
							rsp_valid_q <= 1'b1;
							if (err_q != ST_OK || ended_q) begin
								status_q <= ST_MISPLACE;
							end else if (hc_q != 2'd3) begin
								gbuf_q[8*hc_q +: 8] <= in_byte;
								hc_q <= hc_q + 2'd1;
								if (hc_q == 2'd2) begin
									if (!hdr_magic_ok) begin
										err_q <= ST_MAGIC;
									end else if (!hdr_width_ok) begin
										err_q <= ST_WIDTH;
									end else begin
										mw_q        <= hdr_w;
										bm_q        <= in_byte[7];
										nc_q        <= in_byte[7] ? NW'(257) : NW'(256);
										cw_q        <= LZWZ_MIN_W;
										need_prev_q <= 1'b0;
										gbits_q     <= '0;
										bp_q        <= '0;
									end
								end else if (in_last) begin
									err_q <= ST_SHORT;
								end
								if (in_last) begin
									ended_q <= 1'b1;
								end
							end else if (grp_full && bp_q < gbits_q) begin
								status_q <= ST_MISPLACE;
							end else if (grp_full) begin
								// consumed full group: start a new one
								gbuf_q[7:0] <= in_byte;
								gbits_q     <= 8'd8;
								bp_q        <= '0;
								if (in_last) ended_q <= 1'b1;
							end else begin
								gbuf_q[8*gbits_q[6:3] +: 8] <= in_byte;
								gbits_q <= gbits_q + 8'd8;
								if (in_last) ended_q <= 1'b1;
							end
						end
					end
				end
				S_LOOP: begin
					if (stk_cnt_q != '0) begin
						if (lim_ok) begin
							stk_cnt_q   <= stk_m1;
							out_count_q <= out_count_q + 32'd1;
							state_q     <= S_POP;
						end else begin
							stk_cnt_q <= '0;
						end
					end else if (!ended_q && !grp_full) begin
						rsp_valid_q <= 1'b1;
						need_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else if (!code_fits) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (ended_q) begin
							fin_q <= 1'b1;
						end else begin
							need_q  <= 1'b1;
							gbits_q <= '0;
							bp_q    <= '0;
						end
					end else begin
						bp_q <= bp_q + 8'(cw_q);
						if (code_ext >= nc_q) begin
							err_q       <= ST_CODE;
							rsp_valid_q <= 1'b1;
							fin_q       <= 1'b1;
							status_q    <= ST_CODE;
							state_q     <= S_IDLE;
						end else if (bm_q && code_raw == 16'd256) begin
							// clear code
							gbits_q     <= '0;
							bp_q        <= '0;
							cw_q        <= LZWZ_MIN_W;
							nc_q        <= NW'(257);
							need_prev_q <= 1'b0;
						end else begin
							code_q  <= code_raw;
							cur_q   <= code_raw;
							n_q     <= '0;
							state_q <= (code_raw >= 16'd256) ? S_WALK : S_FIN;
						end
					end
				end
				S_WALK: begin
					// suffix pushed by the request logic; follow parent
					n_q   <= n_p1;
					cur_q <= par_rd;
					if (par_rd < 16'd256) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					stk_cnt_q <= lim_ok ? n_p1 : '0;
					if (nc_q < pow_mw) begin
						need_prev_q <= 1'b1;
						nc_q        <= nc_p1;
						if (nc_p1 > pow_cw && cw_q < mw_q) begin
							gbits_q <= '0;
							bp_q    <= '0;
							cw_q    <= cw_q + 5'd1;
						end
					end else begin
						need_prev_q <= 1'b0;
					end
					// KwKwK: first byte of the string is its own last byte
					state_q <= (need_prev_q && NW'(code_q) == nc_m1) ? S_FIX : S_LOOP;
				end
				S_FIX: begin
					state_q <= S_LOOP;
				end
				S_POP: begin
					rsp_valid_q <= 1'b1;
					out_byte_q  <= stk_rd;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/lzwz_dict.sv -----
// Dictionary (parent, suffix) and expansion stack memories, registered reads.
module lzwz_dict #(
	parameter int AW = lzwz_pkg::LZWZ_AW_MAX
) (
	input  logic                   clk,
	input  lzwz_pkg::lzwz_mem_req_t req,
	output logic [15:0]            par_rd,
	output logic [7:0]             suf_rd,
	output logic [7:0]             stk_rd
);
	import lzwz_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [15:0] parent_mem [DEPTH];
	logic [7:0]  suffix_mem [DEPTH];
	logic [7:0]  stack_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (req.p_we) begin
			parent_mem[req.p_waddr[AW-1:0]] <= req.p_wdata;
		end
		par_rd <= parent_mem[req.d_raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (req.s_we) begin
			suffix_mem[req.s_waddr[AW-1:0]] <= req.s_wdata;
		end
		suf_rd <= suffix_mem[req.d_raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (req.k_we) begin
			stack_mem[req.k_waddr[AW-1:0]] <= req.k_wdata;
		end
		stk_rd <= stack_mem[req.k_raddr[AW-1:0]];
	end

endmodule
